/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared widths, constants and the queue entry type for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int unsigned CP_W          = 21;
	localparam int unsigned QUEUE_DEPTH_D = 4;

	// Lead byte patterns and payload masks.
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;
	localparam logic [7:0] ASCII_LIM  = 8'h80;
	localparam logic [7:0] CONT_MASK  = 8'h3F;

	// (cp - 0x10000) >> 10 equals cp[20:10] - 0x40, so the high surrogate is
	// cp[20:10] + 0xD800 - 0x40 taken modulo 2^16.
	localparam logic [15:0] SURR_HI_BASE = 16'hD800 - 16'h0040;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [9:0]  SURR_LO_MASK = 10'h3FF;

	typedef logic [CP_W-1:0] code_point_t;

	// One entry of the queue between front and back.
	typedef struct packed {
		code_point_t cp;       // completed code point, zero on a bare marker
		logic        has_unit; // a code point was completed by this byte
		logic        last;     // this byte closed the string
	} cp_entry_t;

endpackage

/* rtl/utf8_to_utf16_transcoder_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the s_ group, one per request, with s_tlast on the
// final byte of a string. Units leave on the m_ group; m_tuser[0] says the
// request carries a unit, m_tuser[1] marks the last request caused by an
// input byte, and m_tlast marks the end of the string. A string end that
// completes no code point gives a bare marker with m_tuser[0] low.
// An accepted byte's first unit passes through the queue and then the output register.
// One byte is taken every cycle while the queue has room; a code point above
// 0xFFFF leaves as a surrogate pair, and the unit writer's single output
// register sets the output rate at one unit per cycle while the receiver is ready.
// A queue of QUEUE_DEPTH code points sits between decoder and writer; when the
// receiver stalls, the queue fills and s_tready falls once it is full.
// Reset clears the partial code point, empties the queue and clears the output valid flag.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top #(
	parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic [1:0]  m_tuser,   // [0] unit_valid, [1] last_of_run
	output logic        m_tlast    // string_end
);

	logic                 q_full;
	logic                 push;
	u8u16_pkg::cp_entry_t push_entry;
	logic                 pop;
	logic                 head_valid;
	u8u16_pkg::cp_entry_t head;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

/* rtl/u8u16_front.sv */
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts UTF-8 bytes, assembles code points and queues completed ones and string ends.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] in_byte
	input  logic                  s_tlast,   // last_byte
	input  logic                  q_full,
	output logic                  push,
	output u8u16_pkg::cp_entry_t  push_entry
);

	u8u16_pkg::code_point_t accum_q;
	logic [1:0]             remain_q;

	u8u16_pkg::code_point_t accum_n;
	logic [1:0]             remain_n;
	logic                   done;
	u8u16_pkg::code_point_t cp;
	logic                   fire;

	assign s_tready = !q_full;
	assign fire     = s_tvalid && s_tready;

	always_comb begin
		accum_n  = accum_q;
		remain_n = remain_q;
		done     = 1'b0;
		cp       = '0;
		if (remain_q != 2'd0) begin
			// Any byte counts as a continuation while bytes are owed.
			accum_n  = {accum_q[u8u16_pkg::CP_W-7:0], s_tdata[5:0] & u8u16_pkg::CONT_MASK[5:0]};
			remain_n = remain_q - 2'd1;
			if (remain_q == 2'd1) begin
				done = 1'b1;
				cp   = accum_n;
			end
		end else if (s_tdata < u8u16_pkg::ASCII_LIM) begin
			done = 1'b1;
			cp   = u8u16_pkg::CP_W'(s_tdata);
		end else if ((s_tdata & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_PAT) begin
			accum_n  = u8u16_pkg::CP_W'(s_tdata[4:0]);
			remain_n = 2'd1;
		end else if ((s_tdata & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_PAT) begin
			accum_n  = u8u16_pkg::CP_W'(s_tdata[3:0]);
			remain_n = 2'd2;
		end else if ((s_tdata & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_PAT) begin
			accum_n  = u8u16_pkg::CP_W'(s_tdata[2:0]);
			remain_n = 2'd3;
		end
		if (done) begin
			accum_n = '0;
		end
		if (s_tlast) begin
			accum_n  = '0;
			remain_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			remain_q <= 2'd0;
		end else if (fire) begin
			accum_q  <= accum_n;
			remain_q <= remain_n;
		end
	end

	assign push                = fire && (done || s_tlast);
	assign push_entry.cp       = cp;
	assign push_entry.has_unit = done;
	assign push_entry.last     = s_tlast;

endmodule

/* rtl/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// Transcoder code point queue
// Small circular queue that decouples the front end from the unit writer.
// ----------------------------------------------------------------------------
module u8u16_queue #(
	parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u8u16_pkg::cp_entry_t  push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output u8u16_pkg::cp_entry_t  head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u8u16_pkg::cp_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
`endif

endmodule

/* rtl/u8u16_back.sv */
// ----------------------------------------------------------------------------
// Transcoder unit writer
// Turns queued code points into UTF-16 units and end markers.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  u8u16_pkg::cp_entry_t  head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // [15:0] code_unit
	output logic [1:0]            m_tuser,  // [0] unit_valid, [1] last_of_run
	output logic                  m_tlast   // string_end
);

	logic        m_tvalid_q;
	logic [15:0] unit_q;
	logic        unit_valid_q;
	logic        run_end_q;
	logic        str_end_q;
	logic        half_q;

	logic        load;
	logic        wide;
	logic        emit_high;
	logic [15:0] unit_n;

	assign load      = head_valid && (!m_tvalid_q || m_tready);
	assign wide      = head.has_unit && (head.cp[u8u16_pkg::CP_W-1:16] != '0);
	assign emit_high = wide && !half_q;
	assign pop       = load && !emit_high;

	always_comb begin
		if (!head.has_unit) begin
			unit_n = '0;
		end else if (emit_high) begin
			unit_n = 16'(head.cp[u8u16_pkg::CP_W-1:10]) + u8u16_pkg::SURR_HI_BASE;
		end else if (wide) begin
			unit_n = u8u16_pkg::SURR_LO_BASE | 16'(head.cp[9:0] & u8u16_pkg::SURR_LO_MASK);
		end else begin
			unit_n = head.cp[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			half_q     <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			half_q     <= emit_high;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q       <= unit_n;
			unit_valid_q <= head.has_unit;
			run_end_q    <= !emit_high;
			str_end_q    <= !emit_high && head.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = unit_q;
	assign m_tuser  = {run_end_q, unit_valid_q};
	assign m_tlast  = str_end_q;

`ifndef NO_ASSERTIONS
	// The entry whose high surrogate went out stays at the queue head.
	a_half_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> head_valid && head.has_unit)
		else $error("surrogate pair lost its queue entry");

	a_high_unit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !run_end_q |-> half_q)
		else $error("high surrogate shown without its low half pending");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !unit_valid_q |-> run_end_q && str_end_q && (unit_q == '0))
		else $error("malformed end marker");
`endif

endmodule

/* sim/utf8_to_utf16_transcoder_top_tb.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds UTF-8 strings into the transcoder with random gaps and receiver stalls.
// A bench decoder predicts UTF-16 requests (typed directed rows give their own),
// and every output request is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top_tb;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned CALM_ITEMS   = 120;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_STALL   = 300;
	localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
	localparam logic [20:0] SUPP_OFFSET  = 21'h010000;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [7:0]  CONT_TAG     = 8'h80;
	localparam logic        TYPED        = 1'b1;
	localparam logic        PREDICTED    = 1'b0;

	typedef struct packed {
		logic [15:0] unit;
		logic        valid;
		logic        run_end;
		logic        str_end;
	} utf16_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;   // use the expectation below instead of the decoder
		logic       has_req; // a typed row yields exactly one request when set
		utf16_req_t req;
	} stim_row_t;

	localparam utf16_req_t NO_REQ      = '0;
	localparam utf16_req_t BARE_MARKER = '{16'h0000, 1'b0, 1'b1, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	logic [20:0] partial_cp;
	logic [1:0]  owed_bytes;
	utf16_req_t  expected_reqs [$];
	int unsigned mismatch_count = 0;
	bit          pacing_on      = 1'b1;
	bit          long_stall_req = 1'b0;

	stim_row_t directed_rows [24] = '{
		'{8'h00, 1'b0, TYPED, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b0}},
		'{8'h7F, 1'b1, TYPED, 1'b1, '{16'h007F, 1'b1, 1'b1, 1'b1}},
		'{8'h80, 1'b1, TYPED, 1'b1, BARE_MARKER},
		'{8'hFF, 1'b0, TYPED, 1'b0, NO_REQ},
		'{8'hBF, 1'b0, TYPED, 1'b0, NO_REQ},
		'{8'hF8, 1'b1, TYPED, 1'b1, BARE_MARKER},
		'{8'hC2, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hA9, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hE2, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'h82, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hAC, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hF0, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'h9F, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'h98, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'h80, 1'b0, PREDICTED, 1'b0, NO_REQ},
		// A byte that looks like a stray lead (0xFF) still counts as a continuation.
		'{8'hEF, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hFF, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hBF, 1'b0, PREDICTED, 1'b0, NO_REQ},
		// Largest code point the accumulator holds.
		'{8'hF7, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hBF, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hBF, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'hBF, 1'b1, PREDICTED, 1'b0, NO_REQ},
		// A sequence cut short by the end of the string leaves only the marker.
		'{8'hE2, 1'b0, PREDICTED, 1'b0, NO_REQ},
		'{8'h82, 1'b1, TYPED, 1'b1, BARE_MARKER}
	};

	utf8_to_utf16_transcoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advances the decoder by one byte; when record is set, the requests that
	// the byte causes are queued as expectations.
	function automatic void decode_utf8_byte(input logic [7:0] b, input logic str_last,
			input bit record);
		utf16_req_t  reqs [2];
		int          n;
		bit          done;
		logic [20:0] cp;
		logic [20:0] offs;
		n    = 0;
		done = 1'b0;
		cp   = '0;
		if (owed_bytes != 2'd0) begin
			partial_cp = {partial_cp[14:0], 6'(b & u8u16_pkg::CONT_MASK)};
			owed_bytes = owed_bytes - 2'd1;
			if (owed_bytes == 2'd0) begin
				done = 1'b1;
				cp   = partial_cp;
			end
		end else if (b < u8u16_pkg::ASCII_LIM) begin
			done = 1'b1;
			cp   = {13'd0, b};
		end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_PAT) begin
			partial_cp = {16'd0, b[4:0]};
			owed_bytes = 2'd1;
		end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_PAT) begin
			partial_cp = {17'd0, b[3:0]};
			owed_bytes = 2'd2;
		end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_PAT) begin
			partial_cp = {18'd0, b[2:0]};
			owed_bytes = 2'd3;
		end
		if (done) begin
			partial_cp = '0;
			if (cp <= BMP_MAX) begin
				reqs[0] = '{cp[15:0], 1'b1, 1'b1, str_last};
				n = 1;
			end else begin
				offs    = cp - SUPP_OFFSET;
				reqs[0] = '{16'(offs[20:10]) + HI_SURR_BASE, 1'b1, 1'b0, 1'b0};
				reqs[1] = '{16'(offs[9:0]) + LO_SURR_BASE, 1'b1, 1'b1, str_last};
				n = 2;
			end
		end else if (str_last) begin
			reqs[0] = BARE_MARKER;
			n = 1;
		end
		if (str_last) begin
			partial_cp = '0;
			owed_bytes = 2'd0;
		end
		if (record)
			for (int i = 0; i < n; i++)
				expected_reqs = {expected_reqs, reqs[i]};
	endfunction

	function automatic logic [7:0] cont_byte();
		// Now and then a continuation carries arbitrary top bits.
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return CONT_TAG | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(input int unsigned owed);
		case (owed)
			1:       return u8u16_pkg::LEAD2_PAT | 8'($urandom_range(0, 31));
			2:       return u8u16_pkg::LEAD3_PAT | 8'($urandom_range(0, 15));
			3:       return u8u16_pkg::LEAD4_PAT | 8'($urandom_range(0, 7));
			default: return 8'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch in %s: got %h, expected %h", what, got, want);
		mismatch_count++;
	endtask

	task automatic offer_byte(input logic [7:0] data, input logic str_last);
		if (pacing_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= str_last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly well-formed characters with random payload, mixed with stray
	// bytes and now and then a sequence cut short by the end of the string.
	task automatic send_random_string(inout int unsigned sent);
		logic [7:0]  bytes_q [$];
		int unsigned kind;
		int unsigned owed;
		repeat ($urandom_range(1, 8)) begin
			kind = $urandom_range(0, 99);
			if (kind >= 88) begin
				bytes_q = {bytes_q, $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
					: 8'($urandom_range(8'hF8, 8'hFF))};
			end else begin
				owed = (kind < 30) ? 0 : (kind < 50) ? 1 : (kind < 68) ? 2 : 3;
				bytes_q = {bytes_q, lead_byte(owed)};
				repeat (owed) bytes_q = {bytes_q, cont_byte()};
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			owed = $urandom_range(1, 3);
			bytes_q = {bytes_q, lead_byte(owed)};
			repeat ($urandom_range(0, owed - 1)) bytes_q = {bytes_q, cont_byte()};
		end
		foreach (bytes_q[i]) begin
			offer_byte(bytes_q[i], i == bytes_q.size() - 1);
			decode_utf8_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b1);
			sent++;
		end
	endtask

	initial begin : stimulus
		int unsigned sent;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		partial_cp = '0;
		owed_bytes = '0;
		sent       = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			offer_byte(directed_rows[i].data, directed_rows[i].last);
			decode_utf8_byte(directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].typed == PREDICTED);
			if (directed_rows[i].typed == TYPED && directed_rows[i].has_req)
				expected_reqs = {expected_reqs, directed_rows[i].req};
		end
		// The receiver now holds off for a long stretch while bytes keep coming.
		long_stall_req = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - CALM_ITEMS)
				pacing_on = 1'b0;
			send_random_string(sent);
		end
		s_tvalid <= 1'b0;
		while (expected_reqs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : sink_pacing
		int unsigned stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (long_stall_req) begin
					long_stall_req = 1'b0;
					stall_left     = LONG_STALL;
				end else if (pacing_on && $urandom_range(0, 6) == 0) begin
					stall_left = $urandom_range(1, 13);
				end
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		utf16_req_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_reqs.size() == 0) begin
					report_mismatch("unexpected request, code_unit", m_tdata, 0);
				end else begin
					want = expected_reqs.pop_front();
					if (m_tdata !== want.unit)
						report_mismatch("code_unit", m_tdata, want.unit);
					if (m_tuser[0] !== want.valid)
						report_mismatch("unit_valid", m_tuser[0], want.valid);
					if (m_tuser[1] !== want.run_end)
						report_mismatch("last_of_run", m_tuser[1], want.run_end);
					if (m_tlast !== want.str_end)
						report_mismatch("string_end", m_tlast, want.str_end);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule
